// ===== rtl/hid_message_fragmenter_defines.svh =====
// Assertion macros shared by the HID message fragmenter RTL
`ifndef HID_MESSAGE_FRAGMENTER_DEFINES_SVH
`define HID_MESSAGE_FRAGMENTER_DEFINES_SVH

// check a consequence in the same cycle
`define HIDMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the cycle after the antecedent
`define HIDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hidmf_pkg.sv =====
// Types and constants of the HID message fragmenter
package hidmf_pkg;

	localparam int CHAN_W = 32;
	localparam int CMD_W  = 8;
	localparam int LEN_W  = 16;
	localparam int BYTE_W = 8;
	localparam int REM_W  = 13;
	localparam int SEQ_W  = 7;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	localparam int CMD_INIT_BIT = 7;

	localparam int CHAN_BYTES     = 4;
	localparam int HDR_CMD_POS    = 4;
	localparam int HDR_LEN_HI_POS = 5;
	localparam int HDR_LEN_LO_POS = 6;
	localparam int HDR_INIT_LEN   = 7;
	localparam int CONT_SEQ_POS   = 4;
	localparam int HDR_CONT_LEN   = 5;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_ARGS   = 2'd1,
		ST_NO_MESSAGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_NEW,
		PH_HEAD,
		PH_PAD
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] channel_id;
		logic [CMD_W-1:0]  command;
		logic [LEN_W-1:0]  length;
		logic [BYTE_W-1:0] payload_byte;
	} hidmf_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] report_byte;
		logic              end_of_report;
		logic              end_of_message;
		logic              end_of_run;
		status_t           status;
	} hidmf_out_t;

	typedef struct packed {
		logic fire;
		logic done;
	} hidmf_step_t;

endpackage

// ===== rtl/hidmf_in_stage.sv =====
// Input register of the HID message fragmenter
module hidmf_in_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  hidmf_pkg::hidmf_in_t   item,
	input  hidmf_pkg::hidmf_step_t step,
	output logic                   valid_s1,
	output hidmf_pkg::hidmf_in_t   item_s1
);
	import hidmf_pkg::*;

	logic release_s1;
	logic accept;

	assign release_s1 = step.fire && step.done;
	assign item_stall = valid_s1 && !release_s1;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (release_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/hidmf_emit.sv =====
// Report byte generator and message state of the HID message fragmenter
module hidmf_emit #(
	parameter int REPORT_SIZE = 64,
	parameter int MAX_MESSAGE = 7609
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  hidmf_pkg::hidmf_in_t   item_s1,
	input  logic                   adv,
	output hidmf_pkg::hidmf_out_t  res,
	output hidmf_pkg::hidmf_step_t step
);
	import hidmf_pkg::*;

	localparam int POS_W = $clog2(REPORT_SIZE);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_SIZE - 1);

	phase_t            phase_q, phase_d;
	logic              in_msg_q, in_msg_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic [SEQ_W-1:0]  seq_q, seq_d;
	logic [POS_W-1:0]  pos_q, pos_d;

	logic              fire;
	logic              done;
	logic              pad_go;
	logic              is_new;
	logic              bad;
	logic              hdr_cont;
	logic              at_end;
	logic [POS_W-1:0]  p;
	logic [BYTE_W-1:0] start_byte;
	logic [BYTE_W-1:0] cont_byte;

	function automatic logic [BYTE_W-1:0] chan_byte(logic [CHAN_W-1:0] c, logic [1:0] i);
		return BYTE_W'(c >> {~i, 3'b000});
	endfunction

	assign fire   = valid_s1 && adv;
	assign is_new = phase_q == PH_NEW;
	assign p      = (is_new && item_s1.kind == KIND_START) ? '0 : pos_q;
	assign at_end = p == POS_LAST;
	assign bad    = item_s1.channel_id == '0 || !item_s1.command[CMD_INIT_BIT]
		|| item_s1.length > LEN_W'(MAX_MESSAGE);
	assign hdr_cont = (phase_q == PH_HEAD || pos_q == '0) && p < POS_W'(HDR_CONT_LEN);

	always_comb begin
		if (p < POS_W'(CHAN_BYTES)) begin
			start_byte = chan_byte(item_s1.channel_id, p[1:0]);
		end else if (p == POS_W'(HDR_CMD_POS)) begin
			start_byte = item_s1.command;
		end else if (p == POS_W'(HDR_LEN_HI_POS)) begin
			start_byte = item_s1.length[LEN_W-1:BYTE_W];
		end else begin
			start_byte = item_s1.length[BYTE_W-1:0];
		end
	end

	assign cont_byte = (p < POS_W'(CHAN_BYTES)) ? chan_byte(chan_q, p[1:0])
		: BYTE_W'(seq_q);

	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		done         = 1'b0;
		pad_go       = 1'b0;
		in_msg_d     = in_msg_q;
		chan_d       = chan_q;
		rem_d        = rem_q;
		seq_d        = seq_q;
		pos_d        = pos_q;
		unique case (phase_q)
			PH_PAD: begin
				if (at_end) begin
					res.end_of_report  = 1'b1;
					res.end_of_message = 1'b1;
					res.end_of_run     = 1'b1;
					done               = 1'b1;
					in_msg_d           = 1'b0;
					pos_d              = '0;
				end else begin
					pos_d = p + 1'b1;
				end
			end
			PH_NEW, PH_HEAD: begin
				if (item_s1.kind == KIND_START) begin
					if (is_new && bad) begin
						res.status     = ST_BAD_ARGS;
						res.end_of_run = 1'b1;
						done           = 1'b1;
						in_msg_d       = 1'b0;
						pos_d          = '0;
					end else begin
						res.report_byte = start_byte;
						if (is_new) begin
							chan_d   = item_s1.channel_id;
							seq_d    = '0;
							rem_d    = item_s1.length[REM_W-1:0];
							in_msg_d = 1'b0;
						end
						if (p == POS_W'(HDR_LEN_LO_POS)) begin
							pos_d = POS_W'(HDR_INIT_LEN);
							if (item_s1.length == '0) begin
								pad_go = 1'b1;
							end else begin
								in_msg_d       = 1'b1;
								res.end_of_run = 1'b1;
								done           = 1'b1;
							end
						end else begin
							pos_d = p + 1'b1;
						end
					end
				end else if (is_new && !in_msg_q) begin
					res.status     = ST_NO_MESSAGE;
					res.end_of_run = 1'b1;
					done           = 1'b1;
				end else if (hdr_cont) begin
					res.report_byte = cont_byte;
					if (p == POS_W'(CONT_SEQ_POS)) begin
						seq_d = seq_q + 1'b1;
					end
					pos_d = p + 1'b1;
				end else begin
					res.report_byte = item_s1.payload_byte;
					rem_d           = rem_q - 1'b1;
					if (rem_q == REM_W'(1)) begin
						if (at_end) begin
							res.end_of_report  = 1'b1;
							res.end_of_message = 1'b1;
							res.end_of_run     = 1'b1;
							done               = 1'b1;
							in_msg_d           = 1'b0;
							pos_d              = '0;
						end else begin
							pad_go = 1'b1;
							pos_d  = p + 1'b1;
						end
					end else if (at_end) begin
						res.end_of_report = 1'b1;
						res.end_of_run    = 1'b1;
						done              = 1'b1;
						pos_d             = '0;
					end else begin
						res.end_of_run = 1'b1;
						done           = 1'b1;
						pos_d          = p + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (done) begin
				phase_d = PH_NEW;
			end else if (pad_go || phase_q == PH_PAD) begin
				phase_d = PH_PAD;
			end else begin
				phase_d = PH_HEAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NEW;
			in_msg_q <= 1'b0;
			chan_q   <= '0;
			rem_q    <= '0;
			seq_q    <= '0;
			pos_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			in_msg_q <= in_msg_d;
			chan_q   <= chan_d;
			rem_q    <= rem_d;
			seq_q    <= seq_d;
			pos_q    <= pos_d;
		end
	end

	assign step.fire = fire;
	assign step.done = done;

endmodule

// ===== rtl/hid_message_fragmenter.sv =====
// Top level of the HID message fragmenter
//
// Input channel (item_valid, item_stall, item): one transaction is either the
// start of a message (channel, command, length) or one payload byte.
// Output channel (report_valid, report_stall, report): one transaction per
// report byte, with end-of-report, end-of-message and end-of-run flags and a
// status code; a rejected start or a stray payload byte gives one result.
// An accepted transaction is held in the input register and its results are
// written to the output register, one result per cycle while the receiver
// does not stall: a payload byte inside a report gives one result, a start
// gives the header bytes or a full report when the length is zero, and a
// byte that opens or closes a report adds the header or padding bytes.
// A new transaction is taken in the cycle the last result of the previous
// one is written to the output register.
// Reset clears the message state and empties both registers; no message is
// open afterwards. When the receiver stalls, the output register holds its
// byte and the input stalls once the held transaction has no room to move.
`include "hid_message_fragmenter_defines.svh"

module hid_message_fragmenter #(
	parameter int REPORT_SIZE = 64,
	parameter int MAX_MESSAGE = 7609
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  hidmf_pkg::hidmf_in_t  item,
	output logic                  report_valid,
	input  logic                  report_stall,
	output hidmf_pkg::hidmf_out_t report
);
	import hidmf_pkg::*;

	logic        valid_s1;
	hidmf_in_t   item_s1;
	hidmf_out_t  res;
	hidmf_step_t step;
	logic        adv;
	logic        report_valid_s2;
	hidmf_out_t  report_s2;

	assign adv = !report_valid_s2 || !report_stall;

	hidmf_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.step      (step),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	hidmf_emit #(
		.REPORT_SIZE(REPORT_SIZE),
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.item_s1 (item_s1),
		.adv     (adv),
		.res     (res),
		.step    (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_s2 <= 1'b0;
		end else if (step.fire) begin
			report_valid_s2 <= 1'b1;
		end else if (adv) begin
			report_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			report_s2 <= res;
		end
	end

	assign report_valid = report_valid_s2;
	assign report       = report_s2;

	`HIDMF_ASSERT_NEXT(a_fire_loads, step.fire, report_valid_s2, "result lost after emit")
	`HIDMF_ASSERT_NOW(a_empty_takes, !valid_s1, !item_stall, "input stalled while empty")
	`HIDMF_ASSERT_NOW(a_eom_closes, report_valid_s2 && report_s2.end_of_message, report_s2.end_of_report && report_s2.end_of_run, "message end not at report end")
	`HIDMF_ASSERT_NOW(a_err_single, report_valid_s2 && report_s2.status != ST_OK, report_s2.end_of_run && !report_s2.end_of_report, "error result not alone")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the HID message fragmenter: directed table, then random traffic
module testbench;
	import hidmf_pkg::*;

	localparam int RPT_BYTES   = 64;
	localparam int MAX_LEN     = 7609;
	localparam int RAND_ITEMS  = 260;
	localparam int LONG_HOLD   = 500;
	localparam int HOLD_AFTER  = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		hidmf_in_t it;
		bit        typed;
		status_t   want;
	} plan_row_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	hidmf_in_t  item         = '0;
	logic       report_valid;
	logic       report_stall = 1'b0;
	hidmf_out_t report;

	hidmf_out_t due_bytes[$];
	hidmf_out_t new_bytes[$];

	logic              msg_open   = 1'b0;
	logic [CHAN_W-1:0] msg_chan   = '0;
	logic [REM_W-1:0]  bytes_left = '0;
	logic [SEQ_W-1:0]  seq_no     = '0;
	int                rpt_pos    = 0;

	int fail_count = 0;
	int got_count  = 0;
	int cycles     = 0;
	int items_sent = 0;
	int burst_left = 0;

	int hold_left  = 0;
	bit held       = 1'b0;
	int mode       = 0;
	int mode_left  = 0;
	int stall_tick = 0;

	hid_message_fragmenter #(
		.REPORT_SIZE(RPT_BYTES),
		.MAX_MESSAGE(MAX_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report(report)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void put_byte(logic [7:0] b, status_t st);
		hidmf_out_t r;
		r = '0;
		r.report_byte = b;
		r.status = st;
		new_bytes.push_back(r);
	endfunction

	function automatic void put_chan();
		for (int i = CHAN_BYTES - 1; i >= 0; i--)
			put_byte(msg_chan[8*i +: 8], ST_OK);
	endfunction

	function automatic void pad_report(int pos, bit last);
		int n;
		for (int p = pos; p < RPT_BYTES; p++)
			put_byte(8'h00, ST_OK);
		n = new_bytes.size() - 1;
		new_bytes[n].end_of_report = 1'b1;
		new_bytes[n].end_of_message = last;
	endfunction

	function automatic void fragment_item(hidmf_in_t it);
		int pos;
		int n;
		new_bytes.delete();
		pos = rpt_pos;
		if (it.kind == KIND_START) begin
			msg_open = 1'b0;
			rpt_pos = 0;
			if (it.channel_id == '0 || !it.command[CMD_INIT_BIT]
					|| int'(it.length) > MAX_LEN) begin
				put_byte(8'h00, ST_BAD_ARGS);
			end else begin
				msg_chan = it.channel_id;
				put_chan();
				put_byte(it.command, ST_OK);
				put_byte(it.length[15:8], ST_OK);
				put_byte(it.length[7:0], ST_OK);
				pos = HDR_INIT_LEN;
				seq_no = '0;
				bytes_left = it.length[REM_W-1:0];
				if (bytes_left == '0) begin
					pad_report(pos, 1'b1);
					pos = 0;
				end else begin
					msg_open = 1'b1;
				end
				rpt_pos = pos;
			end
		end else if (!msg_open) begin
			put_byte(8'h00, ST_NO_MESSAGE);
		end else begin
			if (pos == 0) begin
				put_chan();
				put_byte({1'b0, seq_no}, ST_OK);
				seq_no = seq_no + 1'b1;
				pos = HDR_CONT_LEN;
			end
			put_byte(it.payload_byte, ST_OK);
			pos++;
			bytes_left = bytes_left - 1'b1;
			if (bytes_left == '0) begin
				pad_report(pos, 1'b1);
				pos = 0;
				msg_open = 1'b0;
			end else if (pos >= RPT_BYTES) begin
				pad_report(pos, 1'b0);
				pos = 0;
			end
			rpt_pos = pos;
		end
		n = new_bytes.size() - 1;
		new_bytes[n].end_of_run = 1'b1;
	endfunction

	function automatic logic [31:0] any_chan();
		logic [31:0] c;
		c = $urandom;
		if (c == '0)
			c = 32'h1;
		return c;
	endfunction

	function automatic hidmf_in_t start_item(logic [31:0] chan, logic [7:0] cmd, logic [15:0] len);
		hidmf_in_t it;
		it.kind = KIND_START;
		it.channel_id = chan;
		it.command = cmd;
		it.length = len;
		it.payload_byte = 8'($urandom);
		return it;
	endfunction

	function automatic hidmf_in_t byte_item(logic [7:0] b);
		hidmf_in_t it;
		it.kind = KIND_BYTE;
		it.channel_id = $urandom;
		it.command = 8'($urandom);
		it.length = 16'($urandom);
		it.payload_byte = b;
		return it;
	endfunction

	function automatic void flag_fail(string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endfunction

	task automatic send_item(hidmf_in_t it, bit typed = 1'b0, status_t want = ST_OK);
		int gap;
		hidmf_out_t fixed;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
		fragment_item(it);
		if (typed) begin
			fixed = '0;
			fixed.end_of_run = 1'b1;
			fixed.status = want;
			due_bytes.push_back(fixed);
		end else begin
			foreach (new_bytes[i])
				due_bytes.push_back(new_bytes[i]);
		end
		items_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (due_bytes.size() != 0);
	endtask

	// compare each accepted report byte with the oldest expectation
	always @(posedge clk) begin
		hidmf_out_t want;
		if (arst_n && report_valid && !report_stall) begin
			got_count <= got_count + 1;
			if (due_bytes.size() == 0) begin
				flag_fail($sformatf("report %0d: unexpected byte %h status %0d",
					got_count, report.report_byte, report.status));
			end else begin
				want = due_bytes.pop_front();
				if (report.report_byte !== want.report_byte
						|| report.end_of_report !== want.end_of_report
						|| report.end_of_message !== want.end_of_message
						|| report.end_of_run !== want.end_of_run
						|| report.status !== want.status)
					flag_fail($sformatf({"report %0d: expected byte %h eor %b eom %b run %b st %0d,",
						" got byte %h eor %b eom %b run %b st %0d"}, got_count,
						want.report_byte, want.end_of_report, want.end_of_message,
						want.end_of_run, want.status, report.report_byte,
						report.end_of_report, report.end_of_message, report.end_of_run,
						report.status));
			end
		end
	end

	// stall the report side on a pattern of its own, with one long hold
	always @(posedge clk) begin
		logic s;
		stall_tick++;
		if (hold_left > 0) begin
			s = 1'b1;
			hold_left--;
		end else if (!held && got_count >= HOLD_AFTER) begin
			held = 1'b1;
			hold_left = LONG_HOLD;
			s = 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			case (mode)
				0: s = 1'b0;
				1: s = ($urandom_range(0, 3) == 0);
				2: s = ($urandom_range(0, 9) < 7);
				default: s = ((stall_tick % 5) < 2);
			endcase
		end
		report_stall <= s;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		plan_row_t plan[$];
		int r;
		int len;
		int stop_at;
		int start_count;
		plan = '{
			'{byte_item(8'hFF), 1'b1, ST_NO_MESSAGE},
			'{start_item(32'h0, 8'h80, 16'd1), 1'b1, ST_BAD_ARGS},
			'{start_item(32'hFFFFFFFF, 8'h7F, 16'd1), 1'b1, ST_BAD_ARGS},
			'{start_item(32'h1, 8'hFF, 16'(MAX_LEN + 1)), 1'b1, ST_BAD_ARGS},
			'{start_item(32'hFFFFFFFF, 8'hFF, 16'hFFFF), 1'b1, ST_BAD_ARGS},
			'{start_item(32'hFFFFFFFF, 8'hFF, 16'd0), 1'b0, ST_OK},
			'{byte_item(8'h00), 1'b1, ST_NO_MESSAGE},
			'{start_item(32'h00000001, 8'h80, 16'd3), 1'b0, ST_OK},
			'{byte_item(8'h00), 1'b0, ST_OK},
			'{byte_item(8'hFF), 1'b0, ST_OK},
			'{byte_item(8'hA5), 1'b0, ST_OK},
			'{byte_item(8'h5A), 1'b1, ST_NO_MESSAGE},
			'{start_item(32'h12345678, 8'hC1, 16'(MAX_LEN)), 1'b0, ST_OK},
			'{byte_item(8'h01), 1'b0, ST_OK},
			'{start_item(32'hA5A5A5A5, 8'h90, 16'd4), 1'b0, ST_OK},
			'{byte_item(8'h3C), 1'b0, ST_OK},
			'{start_item(32'h0, 8'h00, 16'd0), 1'b1, ST_BAD_ARGS},
			'{byte_item(8'h7E), 1'b1, ST_NO_MESSAGE},
			'{start_item(32'h5A5A5A5A, 8'h86, 16'd1), 1'b0, ST_OK},
			'{byte_item(8'h80), 1'b0, ST_OK}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].it, plan[i].typed, plan[i].want);
		wait_drained();

		start_count = items_sent;
		while (items_sent - start_count < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				wait_drained();
			end else if (r < 12) begin
				case ($urandom_range(0, 2))
					0: send_item(start_item(32'h0, 8'($urandom) | 8'h80,
						16'($urandom_range(0, MAX_LEN))));
					1: send_item(start_item(any_chan(), 8'($urandom_range(0, 127)),
						16'($urandom_range(0, MAX_LEN))));
					default: send_item(start_item(any_chan(), 8'($urandom) | 8'h80,
						16'($urandom_range(MAX_LEN + 1, 65535))));
				endcase
			end else if (r < 18) begin
				repeat ($urandom_range(1, 3))
					send_item(byte_item(8'($urandom)));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					len = 0;
				else if (r < 65)
					len = $urandom_range(1, 20);
				else if (r < 90)
					len = $urandom_range(21, 70);
				else
					len = $urandom_range(71, 130);
				send_item(start_item(any_chan(), 8'($urandom) | 8'h80, 16'(len)));
				// abandon some messages part way through
				stop_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, len) : len;
				if (stop_at > RAND_ITEMS - (items_sent - start_count))
					stop_at = RAND_ITEMS - (items_sent - start_count);
				repeat (stop_at)
					send_item(byte_item(8'($urandom)));
			end
		end
		wait_drained();

		repeat (2 * RPT_BYTES) @(posedge clk);
		if (fail_count == 0 && due_bytes.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
